// ===== rtl/core/chp_pkg.sv =====
// shared types, constants and helpers for the channel histogram with peak
package chp_pkg;

   localparam int COUNT_WIDTH     = 20;
   localparam int OUT_COUNT_WIDTH = 20;
   localparam int PIX_WIDTH       = 8;
   localparam int NUM_BINS        = 256;
   localparam int BIN_WIDTH       = $clog2(NUM_BINS);
   localparam int SUM_WIDTH       = PIX_WIDTH + 2;

   // divide by three as multiply by reciprocal, exact for sums below 2048
   localparam int DIV3_SHIFT = 11;
   localparam int DIV3_MUL   = (1 << DIV3_SHIFT) / 3 + 1;
   localparam int PROD_WIDTH = 2 * SUM_WIDTH;

   localparam int REQ_DATA_WIDTH = 3 * PIX_WIDTH;
   localparam int RSP_DATA_WIDTH = BIN_WIDTH + 2 * OUT_COUNT_WIDTH;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [BIN_WIDTH-1:0]   bin_type;

   typedef enum logic [1:0] {
      SEL_AVERAGE = 2'd0,
      SEL_RED     = 2'd1,
      SEL_GREEN   = 2'd2,
      SEL_BLUE    = 2'd3
   } chan_sel_type;

   // write port of the bin store
   typedef struct packed {
      logic      en;
      bin_type   idx;
      count_type cnt;
   } chp_wr_type;

   function automatic logic [OUT_COUNT_WIDTH-1:0] to_out(input count_type cnt);
      logic [63:0] wide;
      wide = 64'(cnt);
      return wide[OUT_COUNT_WIDTH-1:0];
   endfunction

endpackage

// ===== rtl/core/chp_bin_select.sv =====
// picks the histogram bin from a pixel: one colour or the truncated rgb average
module chp_bin_select (
   input  logic [chp_pkg::PIX_WIDTH-1:0] red,
   input  logic [chp_pkg::PIX_WIDTH-1:0] green,
   input  logic [chp_pkg::PIX_WIDTH-1:0] blue,
   input  chp_pkg::chan_sel_type         sel,
   output chp_pkg::bin_type              bin_idx
);
   import chp_pkg::*;

   logic [SUM_WIDTH-1:0]  sum;
   logic [PROD_WIDTH-1:0] prod;
   bin_type               avg;

   assign sum  = SUM_WIDTH'(red) + SUM_WIDTH'(green) + SUM_WIDTH'(blue);
   assign prod = PROD_WIDTH'(sum) * PROD_WIDTH'(DIV3_MUL);
   assign avg  = prod[DIV3_SHIFT +: BIN_WIDTH];

   always_comb begin
      unique case (sel)
         SEL_RED:   bin_idx = BIN_WIDTH'(red);
         SEL_GREEN: bin_idx = BIN_WIDTH'(green);
         SEL_BLUE:  bin_idx = BIN_WIDTH'(blue);
         default:   bin_idx = avg;
      endcase
   end

endmodule

// ===== rtl/core/chp_bin_store.sv =====
// bin counter memory with per-bin valid bits and forwarding of the last write
module chp_bin_store (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  chp_pkg::bin_type    rd_idx,
   input  chp_pkg::chp_wr_type wr,
   output chp_pkg::count_type  old_cnt
);
   import chp_pkg::*;

   count_type             mem [NUM_BINS];
   logic [NUM_BINS-1:0]   vld_ff;
   count_type             rd_data_ff;
   logic                  rd_vld_ff;
   bin_type               rd_idx_ff;
   logic                  lw_vld_ff;
   bin_type               lw_idx_ff;
   count_type             lw_cnt_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= wr.cnt;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
         rd_idx_ff  <= rd_idx;
      end
      if (wr.en) begin
         lw_idx_ff <= wr.idx;
         lw_cnt_ff <= wr.cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
         lw_vld_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.idx] <= 1'b1;
            lw_vld_ff      <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_idx];
         end
      end
   end

   // the newest write may have landed in the same edge as the read
   always_comb begin
      if (lw_vld_ff && (lw_idx_ff == rd_idx_ff)) begin
         old_cnt = lw_cnt_ff;
      end else if (rd_vld_ff) begin
         old_cnt = rd_data_ff;
      end else begin
         old_cnt = '0;
      end
   end

endmodule

// ===== rtl/core/channel_histogram_with_peak_unit.sv =====
// Histogram of one pixel channel over 256 bins with a running peak count.
// Each accepted pixel leaves one response: bin select into the input register,
// bin store read, then increment and peak update into the response register.
// One pixel per clock is sustained while responses are taken; the bin
// read-modify-write is kept at that rate by forwarding the most recent bin
// write into the increment stage. Each stage moves on as soon as the one ahead
// has room, so up to two more pixels enter while a response waits. Counters
// saturate at their maximum, bin counts clear only at reset (per-bin valid bits,
// no clearing pass), and frame_start clears the peak just before its own pixel
// is counted. csr_wdata[1:0] selects the channel: 0 average of r, g and b,
// 1 red, 2 green, 3 blue; write it idle only.
module channel_histogram_with_peak_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [1:0]                          csr_wdata,     // channel_select
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [chp_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,     // red, green, blue
   input  logic                                req_tuser,     // frame_start
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [chp_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata      // bin_index, bin_count, peak_count
);
   import chp_pkg::*;

   chan_sel_type sel_ff;
   bin_type      sel_idx;

   logic         a_vld_ff, a_vld_in;
   bin_type      a_idx_ff;
   logic         a_fs_ff;
   logic         b_vld_ff, b_vld_in;
   bin_type      b_idx_ff;
   logic         b_fs_ff;
   logic         rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff;
   count_type    peak_ff, peak_in;

   logic         out_free, b_ready, a_ready, a_move, b_move;
   count_type    old_cnt, new_cnt, peak_base;
   chp_wr_type   wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= SEL_AVERAGE;
      end else if (csr_we) begin
         sel_ff <= chan_sel_type'(csr_wdata);
      end
   end

   chp_bin_select u_select (
      .red     (req_tdata[PIX_WIDTH-1:0]),
      .green   (req_tdata[2*PIX_WIDTH-1:PIX_WIDTH]),
      .blue    (req_tdata[3*PIX_WIDTH-1:2*PIX_WIDTH]),
      .sel     (sel_ff),
      .bin_idx (sel_idx)
   );

   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign b_ready    = !b_vld_ff || out_free;
   assign a_ready    = !a_vld_ff || b_ready;
   assign a_move     = a_vld_ff && b_ready;
   assign b_move     = b_vld_ff && out_free;
   assign req_tready = a_ready;

   assign a_vld_in   = (req_tvalid && a_ready) || (a_vld_ff && !b_ready);
   assign b_vld_in   = a_move || (b_vld_ff && !out_free);
   assign rsp_vld_in = b_move || (rsp_vld_ff && !rsp_tready);

   chp_bin_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (a_move),
      .rd_idx  (a_idx_ff),
      .wr      (wr),
      .old_cnt (old_cnt)
   );

   assign new_cnt   = (old_cnt == '1) ? old_cnt : old_cnt + 1'b1;
   assign peak_base = b_fs_ff ? '0 : peak_ff;
   assign peak_in   = (new_cnt > peak_base) ? new_cnt : peak_base;

   assign wr.en  = b_move;
   assign wr.idx = b_idx_ff;
   assign wr.cnt = new_cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
         peak_ff    <= '0;
      end else begin
         a_vld_ff   <= a_vld_in;
         b_vld_ff   <= b_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (b_move) begin
            peak_ff <= peak_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && a_ready) begin
         a_idx_ff <= sel_idx;
         a_fs_ff  <= req_tuser;
      end
      if (a_move) begin
         b_idx_ff <= a_idx_ff;
         b_fs_ff  <= a_fs_ff;
      end
      if (b_move) begin
         rsp_data_ff <= {to_out(peak_in), to_out(new_cnt), b_idx_ff};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/core/chp_checker.sv =====
// port-level checks for the channel histogram unit, bound to the top level
module chp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [chp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);
   import chp_pkg::*;

   localparam int CNT_LO  = BIN_WIDTH;
   localparam int PEAK_LO = BIN_WIDTH + OUT_COUNT_WIDTH;

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // every counted pixel leaves a count of at least one
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[CNT_LO +: OUT_COUNT_WIDTH] != '0))
      else $error("zero bin count on response");

   // the running peak always covers the bin just counted
   a_peak_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[PEAK_LO +: OUT_COUNT_WIDTH] >=
                      rsp_tdata[CNT_LO +: OUT_COUNT_WIDTH]))
      else $error("peak below bin count");

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response changed while stalled");

endmodule

bind channel_histogram_with_peak_unit chp_checker u_chp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/channel_histogram_with_peak_unit_test.sv =====
// testbench for the channel histogram with peak unit
`timescale 1ns / 100ps

module channel_histogram_with_peak_unit_test;
   import chp_pkg::*;

   // limit on the run time; going past it fails the test
   localparam int CYCLE_LIMIT     = 200_000;
   localparam int FULL_RATE_ITEMS = 100;
   localparam count_type COUNT_MAX = '1;

   typedef struct {
      bin_type                    bin;
      logic [OUT_COUNT_WIDTH-1:0] count;
      logic [OUT_COUNT_WIDTH-1:0] peak;
   } bin_update_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      csr_we     = 1'b0;
   logic [1:0]                csr_wdata  = 2'd0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;
   logic                      req_tuser  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;

   // predictor state
   count_type    bin_tally [NUM_BINS];
   count_type    peak_now;
   chan_sel_type chan_now;

   bin_update_type pending_updates [$];
   bin_update_type want_update;

   int  fail_count  = 0;
   int  cycle_count = 0;
   bit  tx_idle_on  = 1'b1;
   bit  rx_idle_on  = 1'b1;

   channel_histogram_with_peak_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic bin_update_type predict_pixel(input logic [7:0] r, input logic [7:0] g,
                                                    input logic [7:0] b, input logic fs);
      bin_update_type res;
      int unsigned    sum;
      bin_type        bin;
      case (chan_now)
         SEL_RED:   bin = r;
         SEL_GREEN: bin = g;
         SEL_BLUE:  bin = b;
         default: begin
            sum = int'(r) + int'(g) + int'(b);
            bin = bin_type'(sum / 3);
         end
      endcase
      if (fs)
         peak_now = '0;
      if (bin_tally[bin] != COUNT_MAX)
         bin_tally[bin] = bin_tally[bin] + 1'b1;
      if (bin_tally[bin] > peak_now)
         peak_now = bin_tally[bin];
      res.bin   = bin;
      res.count = to_out(bin_tally[bin]);
      res.peak  = to_out(peak_now);
      return res;
   endfunction

   task automatic report_mismatch(input string field, input int unsigned want,
                                  input int unsigned got);
      fail_count++;
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
   endtask

   // result side: random back-pressure while rx_idle_on is set, and in-order comparison
   always @(posedge clock) begin
      rsp_tready <= rx_idle_on ? ($urandom_range(99) >= 33) : 1'b1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_updates.size() == 0) begin
            fail_count++;
            $error("response transaction with nothing pending");
         end else begin
            want_update = pending_updates.pop_front();
            if (rsp_tdata[BIN_WIDTH-1:0] !== want_update.bin)
               report_mismatch("bin_index", want_update.bin, rsp_tdata[BIN_WIDTH-1:0]);
            if (rsp_tdata[BIN_WIDTH +: OUT_COUNT_WIDTH] !== want_update.count)
               report_mismatch("bin_count", want_update.count,
                               rsp_tdata[BIN_WIDTH +: OUT_COUNT_WIDTH]);
            if (rsp_tdata[BIN_WIDTH+OUT_COUNT_WIDTH +: OUT_COUNT_WIDTH] !== want_update.peak)
               report_mismatch("peak_count", want_update.peak,
                               rsp_tdata[BIN_WIDTH+OUT_COUNT_WIDTH +: OUT_COUNT_WIDTH]);
         end
      end
   end

   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic fs);
      if (tx_idle_on) begin
         while ($urandom_range(99) < 33) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, g, r};
      req_tuser  <= fs;
      do @(posedge clock); while (!req_tready);
      pending_updates.push_back(predict_pixel(r, g, b, fs));
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_updates.size() != 0);
   endtask

   task automatic write_channel(input chan_sel_type sel);
      hold_until_drained();
      // let the pipeline settle before touching the register
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= sel;
      @(posedge clock);
      csr_we    <= 1'b0;
      chan_now = sel;
   endtask

   task automatic send_random_pixel(input logic [7:0] hot [4], input logic fs);
      int          mode;
      logic [23:0] pix;
      mode = $urandom_range(99);
      if (mode < 45) begin
         pix = {hot[$urandom_range(3)], hot[$urandom_range(3)], hot[$urandom_range(3)]};
      end else if (mode < 55) begin
         pix = {{8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}};
      end else begin
         pix = 24'($urandom);
      end
      send_pixel(pix[7:0], pix[15:8], pix[23:16], fs);
   endtask

   task automatic test_average_extremes();
      write_channel(SEL_AVERAGE);
      send_pixel(8'd0,   8'd0,   8'd0,   1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd254, 1'b0);
      // truncating divide
      send_pixel(8'd1,   8'd1,   8'd0,   1'b0);
      send_pixel(8'd2,   8'd2,   8'd1,   1'b0);
      send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
      send_pixel(8'd0,   8'd128, 8'd1,   1'b0);
   endtask

   task automatic test_single_channels();
      chan_sel_type sels [3];
      sels = '{SEL_RED, SEL_GREEN, SEL_BLUE};
      foreach (sels[i]) begin
         write_channel(sels[i]);
         send_pixel(8'd12,  8'd34,  8'd56,  1'b0);
         send_pixel(8'd255, 8'd0,   8'd128, 1'b0);
         send_pixel(8'd0,   8'd255, 8'd255, 1'b0);
      end
   endtask

   task automatic test_peak_and_frame_start();
      write_channel(SEL_BLUE);
      send_pixel(8'd1, 8'd2, 8'd7,   1'b1);
      send_pixel(8'd3, 8'd4, 8'd7,   1'b0);
      send_pixel(8'd5, 8'd6, 8'd9,   1'b0);
      // equal count leaves the peak alone
      send_pixel(8'd5, 8'd6, 8'd9,   1'b0);
      send_pixel(8'd5, 8'd6, 8'd9,   1'b0);
      // frame start clears only the peak, bins keep counting
      send_pixel(8'd0, 8'd0, 8'd7,   1'b1);
      send_pixel(8'd0, 8'd0, 8'd200, 1'b1);
   endtask

   task automatic run_frames(input chan_sel_type sel, input int count, input bit pause_mid);
      logic [7:0] hot [4];
      int         frame_left;
      logic       fs;
      foreach (hot[i])
         hot[i] = 8'($urandom);
      frame_left = 0;
      write_channel(sel);
      for (int i = 0; i < count; i++) begin
         if (pause_mid && i == count / 2)
            hold_until_drained();
         if (frame_left == 0) begin
            fs = 1'b1;
            frame_left = $urandom_range(60, 1);
         end else begin
            fs = ($urandom_range(99) == 0);
         end
         frame_left--;
         send_random_pixel(hot, fs);
      end
   endtask

   task automatic test_random_frames();
      chan_sel_type plan [5];
      plan = '{SEL_AVERAGE, SEL_BLUE, SEL_RED, SEL_GREEN, chan_sel_type'($urandom_range(3))};
      foreach (plan[p])
         run_frames(plan[p], 210, 1'b1);
   endtask

   task automatic test_full_rate_one_bin();
      logic [7:0] hot_bin;
      write_channel(SEL_RED);
      hot_bin = 8'($urandom);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      // full rate into one bin, each pixel needs the count just written
      for (int i = 0; i < FULL_RATE_ITEMS; i++)
         send_pixel(hot_bin, 8'($urandom), 8'($urandom), 1'(i == 0));
      hold_until_drained();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      send_pixel(8'($urandom), 8'd0, 8'd0, 1'b1);
      send_pixel(hot_bin, 8'd0, 8'd0, 1'b0);
      send_pixel(hot_bin, 8'd255, 8'd255, 1'b1);
      run_frames(chan_sel_type'($urandom_range(3)), 60, 1'b0);
      run_frames(SEL_RED, 60, 1'b0);
   endtask

   initial begin
      foreach (bin_tally[i])
         bin_tally[i] = '0;
      peak_now = '0;
      chan_now = SEL_AVERAGE;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_average_extremes();
      test_single_channels();
      test_peak_and_frame_start();
      test_random_frames();
      test_full_rate_one_bin();

      hold_until_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/chp_pkg.sv
rtl/core/chp_bin_select.sv
rtl/core/chp_bin_store.sv
rtl/core/channel_histogram_with_peak_unit.sv
rtl/core/chp_checker.sv
tb/channel_histogram_with_peak_unit_test.sv
